// ===== sv/rsa_sign_verify_modexp_top_assert.svh =====
// ----------------------------------------------------------------------------
// rsa_sign_verify_modexp_top_assert.svh
// assertion macros for the modular exponentiation engine
// ----------------------------------------------------------------------------
`ifndef RSA_SIGN_VERIFY_MODEXP_TOP_ASSERT_SVH
`define RSA_SIGN_VERIFY_MODEXP_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk and off during rst
`define RSV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk and off during rst
`define RSV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/rsv_pkg.sv =====
// ----------------------------------------------------------------------------
// rsv_pkg
// shared types and reset constants of the modular exponentiation engine
// ----------------------------------------------------------------------------
package rsv_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_DONE
  } rsv_state_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SIGN_MODULUS    = 2'd0,
    REG_SIGN_EXPONENT   = 2'd1,
    REG_VERIFY_MODULUS  = 2'd2,
    REG_VERIFY_EXPONENT = 2'd3
  } rsv_reg_t;

  // request kinds
  localparam logic KIND_SIGN   = 1'b0;
  localparam logic KIND_VERIFY = 1'b1;

  // register reset values
  localparam logic [31:0] SIGN_MODULUS_RST    = 32'd3233;
  localparam logic [31:0] SIGN_EXPONENT_RST   = 32'd413;
  localparam logic [31:0] VERIFY_MODULUS_RST  = 32'd323;
  localparam logic [31:0] VERIFY_EXPONENT_RST = 32'd31;

  localparam int VALUE_W = 32;

endpackage

// ===== sv/rsa_sign_verify_modexp_top.sv =====
// ----------------------------------------------------------------------------
// rsa_sign_verify_modexp_top
// sign / verify engine: bit-serial modular exponentiation under two keys
//
//  channel  dir  signals                     contents
//  s_*      in   tvalid tready tdata tuser   request: value, expected, kind
//  m_*      out  tvalid tready tdata tuser   result: power_result, matches_res
//  cfg_*    in   we index data               key registers
//
// one request at a time: the base is first reduced mod m bit-serially, then
// square-and-multiply scans all W exponent bits, each square and multiply a
// pass of the shared shift-and-add unit; the result is registered once the
// output register is free
// the result register lets the next request start while a result is stalled
// rst is synchronous; registers return to their reset keys
// ----------------------------------------------------------------------------
`include "rsa_sign_verify_modexp_top_assert.svh"

module rsa_sign_verify_modexp_top #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [63:0]           s_tdata,   // [31:0] value, [63:32] expected
  input  logic                  s_tuser,   // [0] kind
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // [31:0] power_result
  output logic                  m_tuser,   // [0] matches_res
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [WORD_WIDTH-1:0] cfg_data
);
  import rsv_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int CW = $clog2(W);

  rsv_state_t state, state_next;

  logic [W-1:0] sign_modulus, sign_exponent, verify_modulus, verify_exponent;

  logic [W-1:0]  m_r;       // active modulus
  logic [W-1:0]  e_r;       // exponent, msb first
  logic [W-1:0]  b_sr;      // serial multiplier operand, msb first
  logic [W-1:0]  mcand;     // parallel multiplicand, holds r between multiplies
  logic [W-1:0]  base;
  logic [W-1:0]  acc;
  logic [W-1:0]  expected_r;
  logic [CW-1:0] cnt;
  logic [CW-1:0] ecnt;
  logic          kind_r;
  logic          small_r;

  logic [W-1:0]  sel_mod;
  logic [W+1:0]  addend, t, m1, m2, red_wide;
  logic [W-1:0]  red, final_val;
  logic          step_last, exp_last, out_free, result_load;

  assign s_tready    = (state == ST_IDLE);
  assign out_free    = !m_tvalid || m_tready;
  assign step_last   = (cnt == CW'(W - 1));
  assign exp_last    = (ecnt == CW'(W - 1));
  assign sel_mod     = s_tuser ? verify_modulus : sign_modulus;
  assign result_load = (state == ST_DONE) && out_free;

  // one step of interleaved reduction: acc = (2*acc + digit*operand) mod m
  always_comb begin
    if (!b_sr[W-1]) begin
      addend = '0;
    end else if (state == ST_REDUCE) begin
      addend = (W+2)'(1);
    end else begin
      addend = {2'b00, mcand};
    end
    t  = {1'b0, acc, 1'b0} + addend;
    m1 = {2'b00, m_r};
    m2 = {1'b0, m_r, 1'b0};
    if (t >= m2) begin
      red_wide = t - m2;
    end else if (t >= m1) begin
      red_wide = t - m1;
    end else begin
      red_wide = t;
    end
    red       = red_wide[W-1:0];
    final_val = small_r ? '0 : mcand;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (step_last) state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (step_last) begin
          if (e_r[W-1]) state_next = ST_MULT;
          else if (exp_last) state_next = ST_DONE;
        end
      end
      ST_MULT: begin
        if (step_last) state_next = exp_last ? ST_DONE : ST_SQUARE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      m_tvalid        <= 1'b0;
      sign_modulus    <= W'(SIGN_MODULUS_RST);
      sign_exponent   <= W'(SIGN_EXPONENT_RST);
      verify_modulus  <= W'(VERIFY_MODULUS_RST);
      verify_exponent <= W'(VERIFY_EXPONENT_RST);
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (rsv_reg_t'(cfg_index))
          REG_SIGN_MODULUS:    sign_modulus    <= cfg_data;
          REG_SIGN_EXPONENT:   sign_exponent   <= cfg_data;
          REG_VERIFY_MODULUS:  verify_modulus  <= cfg_data;
          REG_VERIFY_EXPONENT: verify_exponent <= cfg_data;
        endcase
      end
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          kind_r     <= s_tuser;
          expected_r <= W'(s_tdata[63:32]);
          m_r        <= sel_mod;
          e_r        <= s_tuser ? verify_exponent : sign_exponent;
          small_r    <= (sel_mod < W'(2));
          b_sr       <= W'(s_tdata[31:0]);
          acc        <= '0;
          cnt        <= '0;
        end
      end
      ST_REDUCE: begin
        acc  <= red;
        b_sr <= b_sr << 1;
        cnt  <= cnt + CW'(1);
        if (step_last) begin
          // base reduced; start with r = 1 and square it
          base  <= red;
          acc   <= '0;
          mcand <= W'(1);
          b_sr  <= W'(1);
          cnt   <= '0;
          ecnt  <= '0;
        end
      end
      ST_SQUARE: begin
        acc  <= red;
        b_sr <= b_sr << 1;
        cnt  <= cnt + CW'(1);
        if (step_last) begin
          acc   <= '0;
          cnt   <= '0;
          mcand <= red;
          if (e_r[W-1]) begin
            b_sr <= base;
          end else begin
            b_sr <= red;
            e_r  <= e_r << 1;
            ecnt <= ecnt + CW'(1);
          end
        end
      end
      ST_MULT: begin
        acc  <= red;
        b_sr <= b_sr << 1;
        cnt  <= cnt + CW'(1);
        if (step_last) begin
          acc   <= '0;
          cnt   <= '0;
          mcand <= red;
          b_sr  <= red;
          e_r   <= e_r << 1;
          ecnt  <= ecnt + CW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_tdata <= 32'(final_val);
          m_tuser <= (kind_r == KIND_VERIFY) && (final_val == expected_r);
        end
      end
      default: begin
      end
    endcase
  end

  `RSV_ASSERT_NEXT(a_busy_after_request, s_tvalid && s_tready, !s_tready, "busy request")
  `RSV_ASSERT_NEXT(a_result_presented, result_load, m_tvalid, "result not presented")
  `RSV_ASSERT_NEXT(a_sign_no_match, result_load && kind_r == KIND_SIGN, !m_tuser, "sign flagged")
  `RSV_ASSERT_NOW(a_result_reduced, state == ST_DONE && !small_r, mcand < m_r, "not reduced")

endmodule
